[design/sbs_pkg.sv]
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants for the sorted table bound search
// Action codes, field widths, the sequencer state type and the lane control
// bundle used between the top level and the two search lanes.
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int VAL_W = 32;
  localparam int IDX_W = 11;
  localparam int ACT_W = 2;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } sbs_state_t;

  typedef struct packed {
    logic start;
    logic step;
  } lane_ctl_t;

endpackage

[design/sbs_if.sv]
// ----------------------------------------------------------------------------
// sbs_if: request and response channels of the sorted table bound search
// Both channels use a valid/ready handshake; a transaction completes on a
// rising clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface sbs_req_if;
  import sbs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [VAL_W-1:0] value;

  modport source(output valid, action, value, input ready);
  modport sink(input valid, action, value, output ready);
endinterface

interface sbs_rsp_if;
  import sbs_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] lower_index;
  logic [IDX_W-1:0] upper_index;
  logic             overflowed;

  modport source(output valid, lower_index, upper_index, overflowed, input ready);
  modport sink(input valid, lower_index, upper_index, overflowed, output ready);
endinterface

[design/sbs_mem.sv]
// ----------------------------------------------------------------------------
// sbs_mem: table storage
// One write port and two read ports, each read registered.
// ----------------------------------------------------------------------------
module sbs_mem #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic signed [sbs_pkg::VAL_W-1:0] wdata,
  input  logic                            re,
  input  logic [AW-1:0]                   raddr_a,
  input  logic [AW-1:0]                   raddr_b,
  output logic signed [sbs_pkg::VAL_W-1:0] rdata_a,
  output logic signed [sbs_pkg::VAL_W-1:0] rdata_b
);
  import sbs_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[design/sbs_lane.sv]
// ----------------------------------------------------------------------------
// sbs_lane: one midpoint binary search lane
// Keeps the open window [lo, lim) and the best index found so far. Each step
// consumes the element read at the current midpoint.
// ----------------------------------------------------------------------------
module sbs_lane #(
  parameter int DEPTH  = 1024,
  parameter bit STRICT = 1'b0,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  sbs_pkg::lane_ctl_t               ctl,
  input  logic [CW-1:0]                    count,
  input  logic signed [sbs_pkg::VAL_W-1:0] key,
  input  logic signed [sbs_pkg::VAL_W-1:0] rd_data,
  output logic [AW-1:0]                    mid_addr,
  output logic [CW-1:0]                    found,
  output logic                             done
);
  import sbs_pkg::*;

  logic [CW-1:0] lo;
  logic [CW-1:0] lim;
  logic [CW-1:0] span;
  logic [CW-1:0] mid;
  logic          hit;

  // Same probe as lo + (hi - lo) / 2 with hi = lim - 1.
  assign span     = lim - lo - CW'(1);
  assign mid      = lo + (span >> 1);
  assign mid_addr = mid[AW-1:0];
  assign done     = (lo >= lim);
  assign hit      = STRICT ? (rd_data > key) : (rd_data >= key);

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      lo    <= '0;
      lim   <= count;
      found <= count;
    end else if (ctl.step && !done) begin
      if (hit) begin
        found <= mid;
        lim   <= mid;
      end else begin
        lo <= mid + CW'(1);
      end
    end
  end

endmodule

[design/sorted_table_bound_search.sv]
// ----------------------------------------------------------------------------
// sorted_table_bound_search: lower and upper bound search over a sorted table
// Top level: request decode, fill count, overflow flag, search sequencer and
// the response register.
// ----------------------------------------------------------------------------
// The block keeps up to DEPTH signed 32-bit values in one memory with a write
// port and two registered read ports; the user appends them in nondecreasing
// order, which the block itself does not enforce. A request either clears the
// table, appends its value, or queries its value as a key. Clear and append
// produce no response; an append to a full table is dropped and sets a sticky
// overflow flag that only a clear or a reset clears. A query starts two binary
// search lanes side by side, one for the lower bound (first element >= key)
// and one for the upper bound (first element > key); each yields the fill
// count when nothing qualifies. Each probe issues the memory read in the probe
// state, then compares and narrows the window in the compare state. The probe
// loop through the memory read port sets the query time. The response sits in
// an output register, so the next request is taken while a finished response
// still waits; a second query holds in its last state until the register
// frees up. Indices come out as the low 11 bits of the result.
// ----------------------------------------------------------------------------
module sorted_table_bound_search #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input logic        clk,
  input logic        rst,
  sbs_req_if.sink    req,
  sbs_rsp_if.source  rsp
);
  import sbs_pkg::*;

  sbs_state_t state;
  sbs_state_t state_next;

  logic [CW-1:0]           count;
  logic                    overflow_flag;
  logic signed [VAL_W-1:0] key;

  logic       req_acc;
  logic       is_query;
  logic       table_full;
  logic       mem_we;
  logic       mem_re;
  logic       out_free;
  logic       out_load;
  lane_ctl_t  lane_ctl;

  logic [AW-1:0]           lo_mid;
  logic [AW-1:0]           up_mid;
  logic [CW-1:0]           lo_found;
  logic [CW-1:0]           up_found;
  logic                    lo_done;
  logic                    up_done;
  logic signed [VAL_W-1:0] lo_data;
  logic signed [VAL_W-1:0] up_data;

  logic             rsp_valid;
  logic [IDX_W-1:0] rsp_lower;
  logic [IDX_W-1:0] rsp_upper;
  logic             rsp_ovf;

  // A request transaction completes when the sequencer is idle.
  assign req_acc    = req.valid && req.ready;
  assign is_query   = (req.action == ACT_QUERY);
  assign table_full = (count == CW'(DEPTH));

  // The response register frees up in the same cycle it is drained.
  assign out_free = !rsp_valid || rsp.ready;

  // Appends write straight into the table at the current fill count.
  assign mem_we = req_acc && (req.action == ACT_APPEND) && !table_full;

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_acc && is_query) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (lo_done && up_done) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        state_next = ST_PROBE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs. A probe state issues both reads; the following
  // compare state lets both lanes narrow their windows on the read data.
  always_comb begin
    req.ready      = 1'b0;
    mem_re         = 1'b0;
    out_load       = 1'b0;
    lane_ctl.start = 1'b0;
    lane_ctl.step  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready      = 1'b1;
        lane_ctl.start = req.valid && is_query;
      end
      ST_PROBE: begin
        mem_re = 1'b1;
      end
      ST_CMP: begin
        lane_ctl.step = 1'b1;
      end
      ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      overflow_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (req_acc) begin
        if (req.action == ACT_CLEAR) begin
          count         <= '0;
          overflow_flag <= 1'b0;
        end else if (req.action == ACT_APPEND) begin
          if (table_full) begin
            overflow_flag <= 1'b1;
          end else begin
            count <= count + CW'(1);
          end
        end
      end
    end
  end

  // The key only matters while a query runs, which blocks new requests.
  always_ff @(posedge clk) begin
    if (req_acc && is_query) begin
      key <= req.value;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_lower <= IDX_W'(lo_found);
      rsp_upper <= IDX_W'(up_found);
      rsp_ovf   <= overflow_flag;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.lower_index = rsp_lower;
  assign rsp.upper_index = rsp_upper;
  assign rsp.overflowed  = rsp_ovf;

  sbs_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (count[AW-1:0]),
    .wdata   (req.value),
    .re      (mem_re),
    .raddr_a (lo_mid),
    .raddr_b (up_mid),
    .rdata_a (lo_data),
    .rdata_b (up_data)
  );

  sbs_lane #(
    .DEPTH  (DEPTH),
    .STRICT (1'b0)
  ) u_lane_lower (
    .clk      (clk),
    .ctl      (lane_ctl),
    .count    (count),
    .key      (key),
    .rd_data  (lo_data),
    .mid_addr (lo_mid),
    .found    (lo_found),
    .done     (lo_done)
  );

  sbs_lane #(
    .DEPTH  (DEPTH),
    .STRICT (1'b1)
  ) u_lane_upper (
    .clk      (clk),
    .ctl      (lane_ctl),
    .count    (count),
    .key      (key),
    .rd_data  (up_data),
    .mid_addr (up_mid),
    .found    (up_found),
    .done     (up_done)
  );

endmodule

[design/sbs_checker.sv]
// ----------------------------------------------------------------------------
// sbs_checker: port-level checks for the sorted table bound search
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module sbs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic [sbs_pkg::ACT_W-1:0]   req_action,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [sbs_pkg::IDX_W-1:0]   rsp_lower,
  input logic [sbs_pkg::IDX_W-1:0]   rsp_upper,
  input logic                        rsp_ovf
);
  import sbs_pkg::*;

  logic       query_acc;
  logic       rsp_acc;
  logic [1:0] pending;

  assign query_acc = req_valid && req_ready && (req_action == ACT_QUERY);
  assign rsp_acc   = rsp_valid && rsp_ready;

  // Queries accepted whose responses have not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (query_acc && !rsp_acc) begin
      pending <= pending + 2'd1;
    end else if (rsp_acc && !query_acc) begin
      pending <= pending - 2'd1;
    end
  end

  // A stalled response stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // A stalled response keeps its payload.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_lower) && $stable(rsp_upper) && $stable(rsp_ovf))
    else $error("response payload changed while stalled");

  // Every response belongs to an accepted query.
  a_rsp_owed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("response without an outstanding query");

  // A query occupies the search engine, so no request is taken right after.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    query_acc |=> !req_ready)
    else $error("request taken while a search is running");

endmodule

bind sorted_table_bound_search sbs_checker u_sbs_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_action (req.action),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_lower  (rsp.lower_index),
  .rsp_upper  (rsp.upper_index),
  .rsp_ovf    (rsp.overflowed)
);
